// File: rtl/core/vm_instruction_execute_core_unit_assert.svh
// ----------------------------------------------------------------------------
// vm_instruction_execute_core_unit_assert.svh
// Assertion macros used by the instruction execute core RTL (vmx_back).
// ----------------------------------------------------------------------------
`ifndef VM_INSTRUCTION_EXECUTE_CORE_UNIT_ASSERT_SVH
`define VM_INSTRUCTION_EXECUTE_CORE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every clk edge outside reset.
`define VMX_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every clk edge outside reset.
`define VMX_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define VMX_ASSERT_NOW(lbl, ant, cons, msg)
`define VMX_ASSERT_NEXT(lbl, ant, cons, msg)
`endif

`endif

// File: rtl/core/vmx_pkg.sv
// ----------------------------------------------------------------------------
// vmx_pkg
// Types, decode classes and constants of the instruction execute core.
// ----------------------------------------------------------------------------
package vmx_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [11:0] PC_RESET = 12'h200;
    localparam logic [15:0] INSTR_RET = 16'h00EE;

    // Top nibble of the instruction word
    localparam logic [3:0] NIB_SYS    = 4'h0;
    localparam logic [3:0] NIB_JP     = 4'h1;
    localparam logic [3:0] NIB_CALL   = 4'h2;
    localparam logic [3:0] NIB_SE_IMM = 4'h3;
    localparam logic [3:0] NIB_SNE_IMM = 4'h4;
    localparam logic [3:0] NIB_SE_REG = 4'h5;
    localparam logic [3:0] NIB_LD_IMM = 4'h6;
    localparam logic [3:0] NIB_ADD_IMM = 4'h7;
    localparam logic [3:0] NIB_ALU    = 4'h8;
    localparam logic [3:0] NIB_SNE_REG = 4'h9;
    localparam logic [3:0] NIB_LD_I   = 4'hA;
    localparam logic [3:0] NIB_JP_V0  = 4'hB;
    localparam logic [3:0] NIB_RND    = 4'hC;

    // ALU sub-operations (low nibble of 8XYN)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Decode classes handed from front to back
    localparam logic [3:0] CLS_NOP     = 4'd0;
    localparam logic [3:0] CLS_RET     = 4'd1;
    localparam logic [3:0] CLS_JP      = 4'd2;
    localparam logic [3:0] CLS_CALL    = 4'd3;
    localparam logic [3:0] CLS_SE_IMM  = 4'd4;
    localparam logic [3:0] CLS_SNE_IMM = 4'd5;
    localparam logic [3:0] CLS_SE_REG  = 4'd6;
    localparam logic [3:0] CLS_SNE_REG = 4'd7;
    localparam logic [3:0] CLS_LD_IMM  = 4'd8;
    localparam logic [3:0] CLS_ADD_IMM = 4'd9;
    localparam logic [3:0] CLS_ALU     = 4'd10;
    localparam logic [3:0] CLS_LD_I    = 4'd11;
    localparam logic [3:0] CLS_JP_V0   = 4'd12;
    localparam logic [3:0] CLS_RND     = 4'd13;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_OVER   = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_UNIMPL = 2'd3;

    localparam logic [3:0] VF_IDX = 4'hF;

    typedef struct packed {
        logic [15:0] instruction;
        logic [7:0]  random_byte;
    } in_item_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [11:0] index_value;
        logic        reg_write;
        logic [3:0]  reg_index;
        logic [7:0]  reg_value;
        logic        flag_write;
        logic        flag_value;
        logic        skipped;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  cls;
        logic [3:0]  alu;
        logic [3:0]  x;
        logic [3:0]  ax;
        logic [3:0]  y;
        logic [11:0] nnn;
        logic [7:0]  rnd;
    } dec_t;

endpackage

// File: rtl/core/vmx_front.sv
// ----------------------------------------------------------------------------
// vmx_front
// Accept requests and classify each instruction word for the back end.
// ----------------------------------------------------------------------------
module vmx_front
(
    input  logic              in_valid,
    output logic              in_ready,
    input  vmx_pkg::in_item_t in_data,
    input  logic              q_space,
    output logic              push,
    output vmx_pkg::dec_t     push_data
);
    import vmx_pkg::*;

    logic [3:0] top_nib;
    logic [3:0] low_nib;
    logic [3:0] cls;

    assign top_nib  = in_data.instruction[15:12];
    assign low_nib  = in_data.instruction[3:0];
    assign in_ready = q_space;
    assign push     = in_valid && q_space;

    always_comb
    begin
        case (top_nib)
            NIB_SYS:     cls = (in_data.instruction == INSTR_RET) ? CLS_RET : CLS_NOP;
            NIB_JP:      cls = CLS_JP;
            NIB_CALL:    cls = CLS_CALL;
            NIB_SE_IMM:  cls = CLS_SE_IMM;
            NIB_SNE_IMM: cls = CLS_SNE_IMM;
            NIB_SE_REG:  cls = CLS_SE_REG;
            NIB_LD_IMM:  cls = CLS_LD_IMM;
            NIB_ADD_IMM: cls = CLS_ADD_IMM;
            NIB_ALU:
            begin
                case (low_nib)
                    ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                    ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: cls = CLS_ALU;
                    default: cls = CLS_NOP;
                endcase
            end
            NIB_SNE_REG: cls = CLS_SNE_REG;
            NIB_LD_I:    cls = CLS_LD_I;
            NIB_JP_V0:   cls = CLS_JP_V0;
            NIB_RND:     cls = CLS_RND;
            default:     cls = CLS_NOP;
        endcase
    end

    always_comb
    begin
        push_data.cls = cls;
        push_data.alu = low_nib;
        push_data.x   = in_data.instruction[11:8];
        // offset jump reads V0 on the X port
        push_data.ax  = (cls == CLS_JP_V0) ? 4'h0 : in_data.instruction[11:8];
        push_data.y   = in_data.instruction[7:4];
        push_data.nnn = in_data.instruction[11:0];
        push_data.rnd = in_data.random_byte;
    end

endmodule

// File: rtl/core/vmx_queue.sv
// ----------------------------------------------------------------------------
// vmx_queue
// Short FIFO of decoded requests between front and back.
// ----------------------------------------------------------------------------
module vmx_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vmx_pkg::dec_t push_data,
    input  logic          pop,
    output logic          head_valid,
    output vmx_pkg::dec_t head,
    output logic          space
);
    import vmx_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    dec_t           slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign space      = (cnt_reg < CW'(QUEUE_DEPTH));

endmodule

// File: rtl/core/vmx_back.sv
// ----------------------------------------------------------------------------
// vmx_back
// Execute decoded requests against V registers, PC, I and return stack.
// ----------------------------------------------------------------------------
`include "vm_instruction_execute_core_unit_assert.svh"

module vmx_back
#(
    parameter int STACK_DEPTH = vmx_pkg::STACK_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  vmx_pkg::dec_t      head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output vmx_pkg::out_item_t out_data
);
    import vmx_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // V register file; VF lives in its own flop
    logic [7:0]     vmem [16];
    logic [15:0]    vld_reg;
    logic [7:0]     vf_reg;
    logic [7:0]     rx_reg;
    logic [7:0]     ry_reg;

    // bypass of the write made on the edge that loaded rx/ry
    logic           fwd_vld_reg;
    logic [3:0]     fwd_idx_reg;
    logic [7:0]     fwd_val_reg;

    // return stack; tos_reg mirrors the top entry
    logic [11:0]    stk_mem [STACK_DEPTH];
    logic [11:0]    tos_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;

    logic [11:0]    pc_reg;
    logic [11:0]    idx_reg;

    logic           e_valid_reg;
    dec_t           e_reg;
    logic           e_go;

    logic           o_valid_reg;
    out_item_t      o_reg;

    logic [7:0]     vx, vy, nn, res;
    logic [8:0]     sum9;
    logic [11:0]    here, pc_adv, pc_n, idx_n;
    logic           wr, fw, skip, flag, do_push, do_pop;
    logic [1:0]     st;
    logic [CW-1:0]  cnt_less2;
    out_item_t      res_item;

    assign e_go      = e_valid_reg && (!o_valid_reg || out_ready);
    assign pop       = head_valid && (!e_valid_reg || e_go);
    assign out_valid = o_valid_reg;
    assign out_data  = o_reg;

    // operand select: VF flop, then bypass, then registered RAM read
    always_comb
    begin
        if (e_reg.ax == VF_IDX)
            vx = vf_reg;
        else if (fwd_vld_reg && fwd_idx_reg == e_reg.ax)
            vx = fwd_val_reg;
        else
            vx = rx_reg;

        if (e_reg.y == VF_IDX)
            vy = vf_reg;
        else if (fwd_vld_reg && fwd_idx_reg == e_reg.y)
            vy = fwd_val_reg;
        else
            vy = ry_reg;
    end

    always_comb
    begin
        nn      = e_reg.nnn[7:0];
        here    = pc_reg;
        pc_adv  = pc_reg + 12'd2;
        pc_n    = pc_adv;
        idx_n   = idx_reg;
        wr      = 1'b0;
        fw      = 1'b0;
        skip    = 1'b0;
        res     = '0;
        flag    = 1'b0;
        st      = ST_OK;
        do_push = 1'b0;
        do_pop  = 1'b0;
        sum9    = {1'b0, vx} + {1'b0, vy};

        case (e_reg.cls)
            CLS_RET:
            begin
                if (cnt_reg == '0)
                begin
                    st   = ST_UNDER;
                    pc_n = here;
                end
                else
                begin
                    do_pop = 1'b1;
                    pc_n   = tos_reg;
                end
            end
            CLS_JP:  pc_n = e_reg.nnn;
            CLS_CALL:
            begin
                if (cnt_reg >= CW'(STACK_DEPTH))
                begin
                    st   = ST_OVER;
                    pc_n = here;
                end
                else
                begin
                    do_push = 1'b1;
                    pc_n    = e_reg.nnn;
                end
            end
            CLS_SE_IMM:  skip = (vx == nn);
            CLS_SNE_IMM: skip = (vx != nn);
            CLS_SE_REG:  skip = (vx == vy);
            CLS_SNE_REG: skip = (vx != vy);
            CLS_LD_IMM:
            begin
                wr  = 1'b1;
                res = nn;
            end
            CLS_ADD_IMM:
            begin
                wr  = 1'b1;
                res = vx + nn;
            end
            CLS_ALU:
            begin
                wr = 1'b1;
                case (e_reg.alu)
                    ALU_MOV: res = vy;
                    ALU_OR:  res = vx | vy;
                    ALU_AND: res = vx & vy;
                    ALU_XOR: res = vx ^ vy;
                    ALU_ADD:
                    begin
                        fw   = 1'b1;
                        res  = sum9[7:0];
                        flag = sum9[8];
                    end
                    ALU_SUB:
                    begin
                        fw   = 1'b1;
                        res  = vx - vy;
                        flag = (vx >= vy);
                    end
                    ALU_SHR:
                    begin
                        fw   = 1'b1;
                        res  = {1'b0, vy[7:1]};
                        flag = vy[0];
                    end
                    ALU_SUBN:
                    begin
                        fw   = 1'b1;
                        res  = vy - vx;
                        flag = (vy >= vx);
                    end
                    ALU_SHL:
                    begin
                        fw   = 1'b1;
                        res  = {vy[6:0], 1'b0};
                        flag = vy[7];
                    end
                    default:
                    begin
                        wr = 1'b0;
                        st = ST_UNIMPL;
                    end
                endcase
            end
            CLS_LD_I:  idx_n = e_reg.nnn;
            CLS_JP_V0: pc_n = e_reg.nnn + {4'h0, vx};
            CLS_RND:
            begin
                wr  = 1'b1;
                res = e_reg.rnd & nn;
            end
            default:   st = ST_UNIMPL;
        endcase

        if (skip)
            pc_n = pc_n + 12'd2;

        res_item.next_pc     = pc_n;
        res_item.index_value = idx_n;
        res_item.reg_write   = wr;
        res_item.reg_index   = wr ? e_reg.x : 4'h0;
        res_item.reg_value   = wr ? res : 8'h00;
        res_item.flag_write  = fw;
        res_item.flag_value  = fw ? flag : 1'b0;
        res_item.skipped     = skip;
        res_item.status      = st;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (e_go && do_push)
            cnt_next = cnt_reg + CW'(1);
        else if (e_go && do_pop)
            cnt_next = cnt_reg - CW'(1);
    end

    assign cnt_less2 = cnt_reg - CW'(2);

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            pc_reg      <= PC_RESET;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            vf_reg      <= '0;
            vld_reg     <= '0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                e_valid_reg <= 1'b1;
            else if (e_go)
                e_valid_reg <= 1'b0;

            if (e_go)
                o_valid_reg <= 1'b1;
            else if (out_ready)
                o_valid_reg <= 1'b0;

            cnt_reg <= cnt_next;

            if (e_go)
            begin
                pc_reg      <= pc_n;
                idx_reg     <= idx_n;
                fwd_vld_reg <= wr && (e_reg.x != VF_IDX);
                // flag lands after the result, so it wins when X is F
                if (fw)
                    vf_reg <= {7'h00, flag};
                else if (wr && e_reg.x == VF_IDX)
                    vf_reg <= res;
                if (wr && e_reg.x != VF_IDX)
                    vld_reg[e_reg.x] <= 1'b1;
            end
        end
    end

    // payload registers and RAMs
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_reg  <= head;
            rx_reg <= vld_reg[head.ax] ? vmem[head.ax] : 8'h00;
            ry_reg <= vld_reg[head.y]  ? vmem[head.y]  : 8'h00;
        end
        if (e_go)
        begin
            o_reg       <= res_item;
            fwd_idx_reg <= e_reg.x;
            fwd_val_reg <= res;
            if (wr && e_reg.x != VF_IDX)
                vmem[e_reg.x] <= res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_go && do_push)
        begin
            stk_mem[cnt_reg[AW-1:0]] <= pc_adv;
            tos_reg                  <= pc_adv;
        end
        else if (e_go && do_pop)
        begin
            tos_reg <= stk_mem[cnt_less2[AW-1:0]];
        end
    end

    `VMX_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CW'(STACK_DEPTH), "stack count beyond depth")
    `VMX_ASSERT_NEXT(a_push_cnt, e_go && do_push, cnt_reg == $past(cnt_reg) + CW'(1), "push lost")
    `VMX_ASSERT_NEXT(a_pop_cnt, e_go && do_pop, cnt_reg == $past(cnt_reg) - CW'(1), "pop lost")
    `VMX_ASSERT_NEXT(a_go_out, e_go, o_valid_reg, "executed request not presented")
    `VMX_ASSERT_NOW(a_fwd_vf, fwd_vld_reg, fwd_idx_reg != VF_IDX, "bypass aimed at VF")

endmodule

// File: rtl/core/vm_instruction_execute_core_unit.sv
// ----------------------------------------------------------------------------
// vm_instruction_execute_core_unit
// One instruction per request: classify, queue and execute against V/PC/I.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one request: the
//   instruction word fetched at the current PC and a random byte for CXNN.
//   Output channel (out_valid/out_ready/out_data) returns one result per
//   request, in order: next PC, I, the V register write, the VF flag
//   write, the skip outcome and a status code.
//   Path: an accepted request is written into the queue, popped into the
//   execute register, then executed into the output register.
//   Throughput: one request per cycle while out_ready stays high; the
//   execute loop updates PC, the return stack and VF.
//   in_ready depends only on the queue fill, never on out_ready.
//   When the receiver stalls, the output register holds, execute holds,
//   and the two-entry queue fills before in_ready drops.
//   Reset: PC = 0x200, I = 0, all V registers read as zero, stack empty.
// ----------------------------------------------------------------------------
module vm_instruction_execute_core_unit
#(
    parameter int STACK_DEPTH = vmx_pkg::STACK_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vmx_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output vmx_pkg::out_item_t out_data
);
    import vmx_pkg::*;

    // front to queue
    logic q_push;
    logic q_space;
    dec_t q_push_data;

    // queue to back
    logic q_head_valid;
    logic q_pop;
    dec_t q_head;

    // classify the instruction word and push the decoded request
    vmx_front u_front
    (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_space   (q_space),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // decouple accept from execute so each side can stall on its own
    vmx_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head),
        .space      (q_space)
    );

    // execute against architectural state and hold the result for the sink
    vmx_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the instruction execute core. A driver feeds
// instruction requests from a queue over the valid/ready input channel.
// A monitor predicts each result from its own copy of the V registers, PC,
// I and return stack, and compares every returned result field by field.
// The run goes through phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;
    import vmx_pkg::*;

    localparam int STACK_LIMIT    = STACK_DEPTH_DEF;
    localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
    localparam int STALL_LIMIT    = 2000;  // cycles without any handshake
    localparam int DRAIN_CYCLES   = 8;     // margin after the bench has drained

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Requests waiting for the driver, results waiting for the DUT
    in_item_t  instr_q[$];
    out_item_t pending_results[$];

    // Idling controls, set by the stimulus process
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_asked = 0;

    // Receiver-side hold-off bookkeeping
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;

    logic        req_taken = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;

    // Architectural state of the core as the bench sees it
    logic [7:0]  vreg [16];
    logic [11:0] pc_reg;
    logic [11:0] i_reg;
    logic [11:0] ret_stack [STACK_LIMIT];
    int unsigned stack_fill;

    vm_instruction_execute_core_unit #(
        .STACK_DEPTH (STACK_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Execute one instruction against the bench state and return the
    // result the core must produce for it.
    // ------------------------------------------------------------------
    function automatic out_item_t exec_instr(in_item_t req);
        logic [3:0]  top, x, y, n;
        logic [7:0]  nn, vx, vy, res;
        logic [11:0] nnn, here, pc;
        logic [8:0]  sum;
        logic        wr, fw, skip, flag;
        logic [1:0]  st;
        out_item_t   r;

        top  = req.instruction[15:12];
        x    = req.instruction[11:8];
        y    = req.instruction[7:4];
        n    = req.instruction[3:0];
        nn   = req.instruction[7:0];
        nnn  = req.instruction[11:0];
        here = pc_reg;
        pc   = here + 12'd2;     // advance first, then act
        vx   = vreg[x];
        vy   = vreg[y];
        wr   = 1'b0;
        fw   = 1'b0;
        skip = 1'b0;
        flag = 1'b0;
        res  = '0;
        st   = ST_OK;

        case (top)
            NIB_SYS:
            begin
                if (req.instruction == INSTR_RET)
                begin
                    if (stack_fill == 0)
                    begin
                        st = ST_UNDER;
                        pc = here;
                    end
                    else
                    begin
                        stack_fill--;
                        pc = ret_stack[stack_fill];
                    end
                end
                else
                    st = ST_UNIMPL;
            end
            NIB_JP:
                pc = nnn;
            NIB_CALL:
            begin
                if (stack_fill >= STACK_LIMIT)
                begin
                    st = ST_OVER;
                    pc = here;
                end
                else
                begin
                    ret_stack[stack_fill] = pc;
                    stack_fill++;
                    pc = nnn;
                end
            end
            NIB_SE_IMM:  skip = (vx == nn);
            NIB_SNE_IMM: skip = (vx != nn);
            NIB_SE_REG:  skip = (vx == vy);
            NIB_SNE_REG: skip = (vx != vy);
            NIB_LD_IMM:
            begin
                wr  = 1'b1;
                res = nn;
            end
            NIB_ADD_IMM:
            begin
                wr  = 1'b1;
                res = vx + nn;
            end
            NIB_ALU:
            begin
                wr = 1'b1;
                case (n)
                    ALU_MOV: res = vy;
                    ALU_OR:  res = vx | vy;
                    ALU_AND: res = vx & vy;
                    ALU_XOR: res = vx ^ vy;
                    ALU_ADD:
                    begin
                        fw   = 1'b1;
                        sum  = {1'b0, vx} + {1'b0, vy};
                        res  = sum[7:0];
                        flag = sum[8];
                    end
                    ALU_SUB:
                    begin
                        fw   = 1'b1;
                        res  = vx - vy;
                        flag = (vx >= vy);
                    end
                    ALU_SHR:
                    begin
                        fw   = 1'b1;
                        res  = vy >> 1;
                        flag = vy[0];
                    end
                    ALU_SUBN:
                    begin
                        fw   = 1'b1;
                        res  = vy - vx;
                        flag = (vy >= vx);
                    end
                    ALU_SHL:
                    begin
                        fw   = 1'b1;
                        res  = {vy[6:0], 1'b0};
                        flag = vy[7];
                    end
                    default:
                    begin
                        wr = 1'b0;
                        st = ST_UNIMPL;
                    end
                endcase
            end
            NIB_LD_I:
                i_reg = nnn;
            NIB_JP_V0:
                pc = nnn + {4'h0, vreg[0]};
            NIB_RND:
            begin
                wr  = 1'b1;
                res = req.random_byte & nn;
            end
            default:
                st = ST_UNIMPL;
        endcase

        if (skip)
            pc = pc + 12'd2;
        if (wr)
            vreg[x] = res;
        // VF is written after the result, so the flag wins when X is F
        if (fw)
            vreg[VF_IDX] = {7'h00, flag};
        pc_reg = pc;

        r.next_pc     = pc;
        r.index_value = i_reg;
        r.reg_write   = wr;
        r.reg_index   = wr ? x : 4'h0;
        r.reg_value   = wr ? res : 8'h00;
        r.flag_write  = fw;
        r.flag_value  = fw & flag;
        r.skipped     = skip;
        r.status      = st;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted request, check every accepted
    // result, and count cycles with no handshake for the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;

        req_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            // Check the result before queueing a new prediction so that a
            // result can never be matched against its own request.
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("next_pc", 16'(want.next_pc),
                                16'(out_data.next_pc));
                    check_field("index_value", 16'(want.index_value),
                                16'(out_data.index_value));
                    check_field("reg_write", 16'(want.reg_write),
                                16'(out_data.reg_write));
                    check_field("reg_index", 16'(want.reg_index),
                                16'(out_data.reg_index));
                    check_field("reg_value", 16'(want.reg_value),
                                16'(out_data.reg_value));
                    check_field("flag_write", 16'(want.flag_write),
                                16'(out_data.flag_write));
                    check_field("flag_value", 16'(want.flag_value),
                                16'(out_data.flag_value));
                    check_field("skipped", 16'(want.skipped),
                                16'(out_data.skipped));
                    check_field("status", 16'(want.status),
                                16'(out_data.status));
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(exec_instr(in_data));
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Driver: hold a request until it is taken, then offer the next one
    // or leave in_valid low.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !req_taken)
        begin
            // hold valid and payload
        end
        else if (instr_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            in_valid <= 1'b1;
            in_data  <= instr_q.pop_front();
        end
        else
            in_valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off whenever the stimulus
    // asks for one. The hold is counted here, not in the stimulus.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_done != hold_asked)
        begin
            hold_done++;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: drop out when no request or result moves for too long
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_instr(logic [15:0] word, logic [7:0] rnd);
        in_item_t req;

        req.instruction = word;
        req.random_byte = rnd;
        instr_q.push_back(req);
    endtask

    // Nested calls followed by as many returns; deep chains overflow the
    // stack and then underflow it on the way back.
    task automatic push_call_chain(int unsigned levels);
        for (int unsigned k = 0; k < levels; k++)
            push_instr({NIB_CALL, 12'($urandom_range(0, 4095))}, 8'h00);
        for (int unsigned k = 0; k < levels; k++)
            push_instr(INSTR_RET, 8'h00);
    endtask

    // Random program text. Immediates lean toward small values so that
    // compares hit and registers often hold equal values; calls and returns
    // come at the same rate so the stack wanders up and down.
    task automatic push_random(int unsigned count);
        int unsigned pick;
        logic [3:0]  x, y, sub;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [15:0] word;

        for (int unsigned k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            x    = 4'($urandom_range(0, 15));
            y    = 4'($urandom_range(0, 15));
            nnn  = 12'($urandom_range(0, 4095));
            nn   = 8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                sub = 4'($urandom_range(0, 15));
            else
                case ($urandom_range(0, 8))
                    0: sub = ALU_MOV;
                    1: sub = ALU_OR;
                    2: sub = ALU_AND;
                    3: sub = ALU_XOR;
                    4: sub = ALU_ADD;
                    5: sub = ALU_SUB;
                    6: sub = ALU_SHR;
                    7: sub = ALU_SUBN;
                    default: sub = ALU_SHL;
                endcase

            if (pick < 8)
                word = INSTR_RET;
            else if (pick < 16)
                word = {NIB_CALL, nnn};
            else if (pick < 22)
                word = 16'($urandom_range(0, 65535));
            else if (pick < 28)
                word = {(pick % 2) ? NIB_SE_IMM : NIB_SNE_IMM, x, nn};
            else if (pick < 34)
                word = {(pick % 2) ? NIB_SE_REG : NIB_SNE_REG, x, y, nn[3:0]};
            else if (pick < 44)
                word = {NIB_LD_IMM, x, nn};
            else if (pick < 50)
                word = {NIB_ADD_IMM, x, nn};
            else if (pick < 74)
                word = {NIB_ALU, x, y, sub};
            else if (pick < 78)
                word = {NIB_LD_I, nnn};
            else if (pick < 82)
                word = {NIB_JP_V0, nnn};
            else if (pick < 88)
                word = {NIB_RND, x, nn};
            else if (pick < 94)
                word = {NIB_JP, nnn};
            else
                word = {NIB_SYS, nnn};
            push_instr(word, 8'($urandom_range(0, 255)));
        end
    endtask

    // Hold off the sender until every request went in and every result
    // came back.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (instr_q.size() != 0 || in_valid || pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < 16; k++)
            vreg[k] = 8'h00;
        pc_reg     = PC_RESET;
        i_reg      = 12'h000;
        stack_fill = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling
        push_instr(INSTR_RET, 8'h00);   // return with an empty stack
        push_instr(16'h00E0, 8'h00);    // clear screen is not implemented
        push_instr(16'h60FF, 8'h00);
        push_instr(16'h6101, 8'h00);
        push_instr(16'h8014, 8'h00);    // FF + 01: carry out
        push_instr(16'h8015, 8'h00);    // 00 - 01: borrow
        push_instr(16'h8106, 8'h00);    // shift right out of VY
        push_instr(16'h820E, 8'h00);    // shift left out of VY
        push_instr(16'h8027, 8'h00);    // reverse subtract
        push_instr(16'h8F14, 8'h00);    // X is F: the flag overwrites the sum
        push_instr(16'h8121, 8'h00);
        push_instr(16'h812B, 8'h00);    // ALU sub-op without a meaning
        push_instr(16'h7FFF, 8'h00);    // add immediate into VF: 00 + FF, no wrap
        push_instr(16'h30FF, 8'h00);
        push_instr(16'h40FF, 8'h00);
        push_instr(16'h5001, 8'h00);    // low nibble of a register compare ignored
        push_instr(16'h900F, 8'h00);
        push_instr(16'hAFFF, 8'h00);
        push_instr(16'hBFFF, 8'h00);    // offset jump wraps past 0xFFF
        push_instr(16'hC0F0, 8'hA5);
        push_instr(16'h2ABC, 8'h00);
        push_instr(INSTR_RET, 8'h00);
        push_instr(16'h1FFE, 8'h00);    // jump to 0xFFE: the next PC advance wraps to zero
        push_instr(16'h4000, 8'hFF);
        push_instr(16'hD123, 8'hFF);
        push_instr(16'hF107, 8'hFF);
        push_call_chain(STACK_LIMIT + 2);
        push_random(180);
        wait_drained();

        // Sender idles often
        send_idle_pct  = 57;
        recv_stall_pct = 0;
        push_random(200);
        wait_drained();

        // Receiver stalls often
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        push_call_chain(STACK_LIMIT + 1);
        push_random(180);
        wait_drained();

        // Both sides idle now and then
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        push_random(160);
        push_call_chain(4);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering: the core
        // must fill and drop in_ready, then drain without loss.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asked++;
        push_random(120);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/vmx_pkg.sv
rtl/core/vmx_front.sv
rtl/core/vmx_queue.sv
rtl/core/vmx_back.sv
rtl/core/vm_instruction_execute_core_unit.sv
tb/tb_top.sv
